// ===== hw/rtl/srps_pkg.sv =====
package srps_pkg;

	localparam int SECTOR_W    = 48;
	localparam int DIVD_W      = SECTOR_W + 1;
	localparam int CNT_W       = 7;
	localparam int OFF_W       = 6;
	localparam int REQ_W       = 16;
	localparam int MASK_W      = 64;
	localparam int OUT_LIMIT   = 33;
	localparam int PIECE_IDX_W = 6;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_PAGE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END        = 2'd2;

	localparam logic [CNT_W-1:0]    SPP_RESET       = 7'd8;
	localparam logic [CNT_W-1:0]    SPP_MIN         = 7'd8;
	localparam logic [CNT_W-1:0]    SPP_MAX         = 7'd64;
	localparam logic [SECTOR_W-1:0] RANGE_END_RESET = {SECTOR_W{1'b1}};

	typedef struct packed {
		logic [SECTOR_W-1:0] start_sector;
		logic [REQ_W-1:0]    request_sectors;
		logic                is_write;
	} cmd_t;

	typedef struct packed {
		logic [SECTOR_W-1:0] page_number;
		logic [CNT_W-1:0]    piece_sectors;
		logic [MASK_W-1:0]   sector_mask;
		logic                write_flag;
		logic                error_flag;
		logic                last_piece;
	} result_t;

	typedef struct packed {
		logic [DIVD_W-1:0]   dividend;
		logic [SECTOR_W-1:0] divisor;
	} div_in_t;

	typedef struct packed {
		logic [DIVD_W-1:0]   quotient;
		logic [SECTOR_W-1:0] remainder;
	} div_out_t;

endpackage

// ===== hw/rtl/srps_div.sv =====
module srps_div import srps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     go,
	input  div_in_t  operand,
	output logic     done,
	output div_out_t result
);

	localparam int STEPS  = DIVD_W;
	localparam int STEP_W = $clog2(STEPS + 1);

	logic                running_q;
	logic [STEP_W-1:0]   step_q;
	logic [SECTOR_W-1:0] rem_q;
	logic [SECTOR_W-1:0] dvs_q;
	logic [DIVD_W-1:0]   quo_q;
	logic [SECTOR_W:0]   trial;
	logic [SECTOR_W:0]   diff;
	logic                fits;

	// Restoring division, one quotient bit per cycle. The dividend shifts out of
	// the top of quo_q while quotient bits shift in at the bottom.
	always_comb begin
		trial = {rem_q, quo_q[DIVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			step_q    <= '0;
			done      <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				running_q <= 1'b1;
				step_q    <= '0;
			end else if (running_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(STEPS - 1)) begin
					running_q <= 1'b0;
					done      <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= operand.dividend;
			dvs_q <= operand.divisor;
		end else if (running_q) begin
			rem_q <= fits ? diff[SECTOR_W-1:0] : trial[SECTOR_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign result.quotient  = quo_q;
	assign result.remainder = rem_q;

endmodule

// ===== hw/rtl/sector_request_page_splitter_core.sv =====
// Sector request page splitter.
// Command channel: a request beat (cmd) is taken at a clock edge where start is
// high and busy is low. Each result beat shows on result for one cycle with
// result_valid high; the receiver must take it then, there is no back-pressure.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, and writes belong in idle periods only.
// Timing: a zero-size request returns no result and busy never rises. A rejected
// request returns its single error beat in the cycle after it is taken. Otherwise
// the block first finds the range start modulo the page size, then divides each
// piece's range-relative sector by the page size, after a division by the range
// span for a piece whose sector wraps into the range. All of this goes through
// one shared divider that yields one quotient bit per cycle. Pieces are held in
// a 33-entry buffer and stream out one per cycle only once the split ends, so
// that a request which would need too many pieces gives only its error beat. busy
// stays high until the last beat is in the output register, so a new request is
// taken right after. Reset puts the configuration registers at their defaults and
// drops any request in flight.
module sector_request_page_splitter_core import srps_pkg::*; #(
	parameter int MAX_REQ_SECTORS = 256,
	parameter int MASK_BITS       = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cmd_t                 cmd,
	output logic                 result_valid,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SECTOR_W-1:0]  cfg_data
);

	localparam logic [REQ_W:0]     MAX_REQ    = (REQ_W + 1)'(MAX_REQ_SECTORS);
	localparam logic [CNT_W-1:0]   MASK_LIMIT = CNT_W'(MASK_BITS);
	localparam logic [MASK_W-1:0]  MASK_KEEP  = (MASK_BITS >= MASK_W) ? {MASK_W{1'b1}} :
		~({MASK_W{1'b1}} << MASK_BITS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_CHECK,
		ST_WRAP,
		ST_PAGE,
		ST_STEP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [SECTOR_W-1:0] page;
		logic [CNT_W-1:0]    cnt;
		logic [OFF_W-1:0]    off;
	} piece_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       spp_q;
	logic [SECTOR_W-1:0]    rstart_q;
	logic [SECTOR_W-1:0]    rend_q;
	logic [DIVD_W-1:0]      lsa_q;
	logic [REQ_W-1:0]       req_q;
	logic [REQ_W-1:0]       done_q;
	logic                   wr_q;
	logic [PIECE_IDX_W-1:0] k_q;
	logic [PIECE_IDX_W-1:0] n_q;
	logic [PIECE_IDX_W-1:0] rd_ptr_q;
	logic [OFF_W-1:0]       s0_q;
	logic [SECTOR_W-1:0]    page_q;
	logic [OFF_W-1:0]       off_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   div_go_q;
	div_in_t                div_in_q;
	logic                   div_done;
	div_out_t               div_res;
	piece_t                 mem_q [OUT_LIMIT];
	piece_t                 rd_data_s1;
	logic                   rd_vld_s1;
	logic                   rd_last_s1;

	logic                   accept;
	logic                   range_bad;
	logic                   spp_bad;
	logic                   req_big;
	logic                   out_of_range;
	logic [SECTOR_W-1:0]    rel_now;
	logic [SECTOR_W-1:0]    span;
	logic [CNT_W-1:0]       mod_sum;
	logic [CNT_W-1:0]       lsa_mod;
	logic [CNT_W-1:0]       cnt_full;
	logic [REQ_W:0]         reach;
	logic [REQ_W-1:0]       left;
	logic [CNT_W-1:0]       cnt_fin;
	logic                   mem_we;
	piece_t                 wentry;
	logic [MASK_W-1:0]      ones;
	logic [MASK_W-1:0]      mask;

	srps_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (div_go_q),
		.operand (div_in_q),
		.done    (div_done),
		.result  (div_res)
	);

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE) || rd_vld_s1;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q    <= SPP_RESET;
			rstart_q <= '0;
			rend_q   <= RANGE_END_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SECTORS_PER_PAGE: spp_q    <= cfg_data[CNT_W-1:0];
				CFG_RANGE_START:      rstart_q <= cfg_data;
				CFG_RANGE_END:        rend_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		range_bad    = rend_q <= rstart_q;
		spp_bad      = (spp_q < SPP_MIN) || (spp_q > SPP_MAX) || (spp_q > MASK_LIMIT);
		req_big      = {1'b0, cmd.request_sectors} > MAX_REQ;
		out_of_range = (lsa_q < {1'b0, rstart_q}) || (lsa_q > {1'b0, rend_q});
		rel_now      = lsa_q[SECTOR_W-1:0] - rstart_q;
		span         = rend_q - rstart_q;

		// The absolute sector's offset in its page follows from the range-relative
		// offset plus the range start's own offset, folded once.
		mod_sum  = CNT_W'(div_res.remainder[OFF_W-1:0]) + CNT_W'(s0_q);
		lsa_mod  = (mod_sum >= spp_q) ? mod_sum - spp_q : mod_sum;
		cnt_full = spp_q - lsa_mod;

		reach   = {1'b0, done_q} + (REQ_W + 1)'(cnt_q);
		left    = req_q - done_q;
		cnt_fin = (reach >= {1'b0, req_q}) ? left[CNT_W-1:0] : cnt_q;

		mem_we      = state_q == ST_STEP;
		wentry.page = page_q;
		wentry.cnt  = cnt_fin;
		wentry.off  = off_q;

		ones = rd_data_s1.cnt[CNT_W-1] ? {MASK_W{1'b1}} : ~({MASK_W{1'b1}} << rd_data_s1.cnt);
		mask = (ones << rd_data_s1.off) & MASK_KEEP;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[k_q] <= wentry;
		end
		rd_data_s1 <= mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			div_go_q     <= 1'b0;
			div_in_q     <= '0;
			result_valid <= 1'b0;
			result       <= '0;
			rd_vld_s1    <= 1'b0;
			rd_last_s1   <= 1'b0;
			lsa_q        <= '0;
			req_q        <= '0;
			done_q       <= '0;
			wr_q         <= 1'b0;
			k_q          <= '0;
			n_q          <= '0;
			rd_ptr_q     <= '0;
			s0_q         <= '0;
			page_q       <= '0;
			off_q        <= '0;
			cnt_q        <= '0;
		end else begin
			div_go_q     <= 1'b0;
			result_valid <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rd_last_s1   <= 1'b0;

			if (rd_vld_s1) begin
				result_valid         <= 1'b1;
				result.page_number   <= rd_data_s1.page;
				result.piece_sectors <= rd_data_s1.cnt;
				result.sector_mask   <= mask;
				result.write_flag    <= wr_q;
				result.error_flag    <= 1'b0;
				result.last_piece    <= rd_last_s1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						lsa_q  <= {1'b0, cmd.start_sector};
						req_q  <= cmd.request_sectors;
						wr_q   <= cmd.is_write;
						done_q <= '0;
						k_q    <= '0;
						if (cmd.request_sectors == '0) begin
							state_q <= ST_IDLE;
						end else if (req_big || range_bad || spp_bad) begin
							result_valid            <= 1'b1;
							result                  <= '0;
							result.write_flag       <= cmd.is_write;
							result.error_flag       <= 1'b1;
							result.last_piece       <= 1'b1;
						end else begin
							div_in_q.dividend <= {1'b0, rstart_q};
							div_in_q.divisor  <= SECTOR_W'(spp_q);
							div_go_q          <= 1'b1;
							state_q           <= ST_BASE;
						end
					end
				end
				ST_BASE: begin
					if (div_done) begin
						s0_q    <= div_res.remainder[OFF_W-1:0];
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (done_q == req_q) begin
						n_q      <= k_q;
						rd_ptr_q <= '0;
						state_q  <= ST_EMIT;
					end else if (k_q == PIECE_IDX_W'(OUT_LIMIT)) begin
						result_valid      <= 1'b1;
						result            <= '0;
						result.write_flag <= wr_q;
						result.error_flag <= 1'b1;
						result.last_piece <= 1'b1;
						state_q           <= ST_IDLE;
					end else if (out_of_range) begin
						div_in_q.dividend <= lsa_q;
						div_in_q.divisor  <= span;
						div_go_q          <= 1'b1;
						state_q           <= ST_WRAP;
					end else begin
						div_in_q.dividend <= {1'b0, rel_now};
						div_in_q.divisor  <= SECTOR_W'(spp_q);
						div_go_q          <= 1'b1;
						state_q           <= ST_PAGE;
					end
				end
				ST_WRAP: begin
					// After the wrap the range-relative sector is the remainder itself.
					if (div_done) begin
						lsa_q             <= {1'b0, rstart_q + div_res.remainder};
						div_in_q.dividend <= {1'b0, div_res.remainder};
						div_in_q.divisor  <= SECTOR_W'(spp_q);
						div_go_q          <= 1'b1;
						state_q           <= ST_PAGE;
					end
				end
				ST_PAGE: begin
					if (div_done) begin
						page_q  <= div_res.quotient[SECTOR_W-1:0];
						off_q   <= div_res.remainder[OFF_W-1:0];
						cnt_q   <= cnt_full;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					k_q     <= k_q + PIECE_IDX_W'(1);
					lsa_q   <= lsa_q + DIVD_W'(cnt_fin);
					done_q  <= done_q + REQ_W'(cnt_fin);
					state_q <= ST_CHECK;
				end
				ST_EMIT: begin
					rd_vld_s1  <= 1'b1;
					rd_last_s1 <= rd_ptr_q == (n_q - PIECE_IDX_W'(1));
					if (rd_ptr_q == (n_q - PIECE_IDX_W'(1))) begin
						rd_ptr_q <= '0;
						state_q  <= ST_IDLE;
					end else begin
						rd_ptr_q <= rd_ptr_q + PIECE_IDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_BASE || state_q == ST_WRAP || state_q == ST_PAGE))
		else $error("divider finished outside a wait state");

	a_piece_limit: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= PIECE_IDX_W'(OUT_LIMIT))
		else $error("piece buffer index beyond its depth");

	a_done_within_req: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (done_q <= req_q))
		else $error("covered sectors exceed the request");

	a_zero_req_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd.request_sectors == '0) |=> !result_valid)
		else $error("zero-size request produced a result");
`endif

endmodule

// ===== dv/sector_request_page_splitter_core_tb.sv =====
module sector_request_page_splitter_core_tb;
	import srps_pkg::*;

	localparam int MAX_REQ_SECTORS = 256;
	localparam int MASK_BITS       = 64;
	localparam int CYCLE_LIMIT     = 2500000;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int SETTLE_CYCLES   = 8;
	localparam int TAIL_CYCLES     = 150;
	localparam logic [SECTOR_W-1:0] SECTOR_MAX = {SECTOR_W{1'b1}};

	class split_scoreboard;
		logic [63:0] page_size = 64'(SPP_RESET);
		logic [63:0] range_lo  = 64'd0;
		logic [63:0] range_hi  = 64'(RANGE_END_RESET);
		result_t     pending_pieces[$];
		int unsigned errors         = 0;
		int unsigned requests       = 0;
		int unsigned empty_requests = 0;
		int unsigned rejects        = 0;
		int unsigned beats          = 0;
		int unsigned settings       = 0;

		task report(string msg);
			errors++;
			$display("MISMATCH: %s", msg);
		endtask

		function int unsigned pending();
			return pending_pieces.size();
		endfunction

		function void add_expected(result_t r);
			pending_pieces = {pending_pieces, r};
		endfunction

		function void note_config(logic [CFG_IDX_W-1:0] idx, logic [SECTOR_W-1:0] data);
			case (idx)
				CFG_SECTORS_PER_PAGE: begin
					page_size = 64'(data[CNT_W-1:0]);
				end
				CFG_RANGE_START: begin
					range_lo = 64'(data);
				end
				CFG_RANGE_END: begin
					range_hi = 64'(data);
				end
				default: begin
				end
			endcase
		endfunction

		function logic [63:0] ones_below(logic [63:0] n);
			if (n >= 64) begin
				return {64{1'b1}};
			end
			return ~({64{1'b1}} << n);
		endfunction

		function void push_reject(logic wr);
			result_t piece;
			piece = '0;
			piece.write_flag = wr;
			piece.error_flag = 1'b1;
			piece.last_piece = 1'b1;
			rejects++;
			add_expected(piece);
		endfunction

		// Splits one request into its page pieces under the current register values.
		function void note_request(cmd_t c);
			logic [63:0] lsa;
			logic [63:0] want;
			logic [63:0] done;
			logic [63:0] rel;
			logic [63:0] cnt;
			result_t     piece;
			result_t     split[$];
			requests++;
			lsa = 64'(c.start_sector);
			want = 64'(c.request_sectors);
			done = 64'd0;
			piece = '0;
			piece.write_flag = c.is_write;
			if (want == 0) begin
				empty_requests++;
				return;
			end
			if (want > MAX_REQ_SECTORS || range_hi <= range_lo || page_size < SPP_MIN ||
			    page_size > SPP_MAX || page_size > MASK_BITS) begin
				push_reject(c.is_write);
				return;
			end
			while (done < want) begin
				// A request that wraps through a tiny range can need more pieces than
				// the buffer holds; it then yields only the error beat.
				if (split.size() >= OUT_LIMIT) begin
					push_reject(c.is_write);
					return;
				end
				if (lsa < range_lo || lsa > range_hi) begin
					lsa = range_lo + lsa % (range_hi - range_lo);
				end
				rel = lsa - range_lo;
				// The piece length follows the absolute sector, while the bitmap offset
				// follows the range-relative one, so high mask bits can spill off.
				cnt = page_size - lsa % page_size;
				piece.last_piece = 1'b0;
				if (done + cnt >= want) begin
					cnt = want - done;
					piece.last_piece = 1'b1;
				end
				piece.page_number = SECTOR_W'(rel / page_size);
				piece.piece_sectors = CNT_W'(cnt);
				piece.sector_mask = ones_below(cnt) << (rel % page_size);
				split = {split, piece};
				lsa += cnt;
				done += cnt;
			end
			pending_pieces = {pending_pieces, split};
		endfunction

		task check_result(result_t got);
			result_t want;
			beats++;
			if (pending_pieces.size() == 0) begin
				report($sformatf("result beat with nothing expected: page %0h cnt %0d err %0b",
					got.page_number, got.piece_sectors, got.error_flag));
				return;
			end
			want = pending_pieces[0];
			pending_pieces.delete(0);
			if (got.page_number !== want.page_number) begin
				report($sformatf("page_number got %0h exp %0h", got.page_number,
					want.page_number));
			end
			if (got.piece_sectors !== want.piece_sectors) begin
				report($sformatf("piece_sectors got %0d exp %0d (page %0h)", got.piece_sectors,
					want.piece_sectors, want.page_number));
			end
			if (got.sector_mask !== want.sector_mask) begin
				report($sformatf("sector_mask got %h exp %h (page %0h)", got.sector_mask,
					want.sector_mask, want.page_number));
			end
			if (got.write_flag !== want.write_flag) begin
				report($sformatf("write_flag got %b exp %b (page %0h)", got.write_flag,
					want.write_flag, want.page_number));
			end
			if (got.error_flag !== want.error_flag) begin
				report($sformatf("error_flag got %b exp %b (page %0h)", got.error_flag,
					want.error_flag, want.page_number));
			end
			if (got.last_piece !== want.last_piece) begin
				report($sformatf("last_piece got %b exp %b (page %0h)", got.last_piece,
					want.last_piece, want.page_number));
			end
		endtask

		task close_out();
			while (pending_pieces.size() != 0) begin
				report($sformatf("result never arrived: page %0h cnt %0d err %0b",
					pending_pieces[0].page_number, pending_pieces[0].piece_sectors,
					pending_pieces[0].error_flag));
				pending_pieces.delete(0);
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	cmd_t                 cmd;
	logic                 result_valid;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SECTOR_W-1:0]  cfg_data;
	int unsigned          cycles_run;
	split_scoreboard      sb;

	sector_request_page_splitter_core #(
		.MAX_REQ_SECTORS(MAX_REQ_SECTORS),
		.MASK_BITS      (MASK_BITS)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.result_valid(result_valid),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				sb.note_config(cfg_index, cfg_data);
			end
			if (start && !busy) begin
				sb.note_request(cmd);
			end
			if (result_valid) begin
				sb.check_result(result);
			end
		end
	end

	initial begin
		cycles_run = 0;
		while (cycles_run < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles_run++;
		end
		$display("Run stopped after %0d cycles with %0d beats outstanding", cycles_run,
			sb.pending());
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end
		if (roll < 90) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(10, 80);
	endfunction

	function automatic logic [SECTOR_W-1:0] range_top(input logic [63:0] lo, input logic [63:0] span);
		if (lo + span > 64'(SECTOR_MAX)) begin
			return SECTOR_MAX;
		end
		return SECTOR_W'(lo + span);
	endfunction

	// Mostly requests that start inside the range with modest sizes; the rest
	// start near the top of the range, anywhere at all, are empty or oversize.
	function automatic cmd_t random_cmd(input logic [63:0] lo, input logic [63:0] hi);
		cmd_t        c;
		logic [63:0] span;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		span = hi - lo;
		c.is_write = 1'($urandom_range(0, 1));
		c.start_sector = SECTOR_W'({$urandom, $urandom});
		if (roll < 5) begin
			c.request_sectors = '0;
		end else if (roll < 10) begin
			c.request_sectors = REQ_W'($urandom_range(MAX_REQ_SECTORS + 1, 65535));
		end else if (roll < 20) begin
			c.request_sectors = REQ_W'($urandom_range(1, MAX_REQ_SECTORS));
		end else begin
			if ($urandom_range(0, 4) == 0) begin
				c.request_sectors = REQ_W'($urandom_range(1, MAX_REQ_SECTORS));
			end else begin
				c.request_sectors = REQ_W'($urandom_range(1, 40));
			end
			if (roll < 30) begin
				c.start_sector = SECTOR_W'(hi - 64'($urandom_range(0, 12)) % (span + 1));
			end else begin
				c.start_sector = SECTOR_W'(lo + {$urandom, $urandom} % (span + 1));
			end
		end
		return c;
	endfunction

	task automatic send_cmd(input cmd_t c);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
	endtask

	// Leaves start high when no gap follows, so back-to-back requests never
	// lower and raise it within one step.
	task automatic pause_sender(input int unsigned cycles);
		if (cycles != 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic drain();
		int unsigned waited;
		waited = 0;
		start <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while ((sb.pending() != 0 || busy) && waited < DRAIN_LIMIT);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SECTOR_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_config(input logic [SECTOR_W-1:0] spp_word,
	                            input logic [SECTOR_W-1:0] lo, input logic [SECTOR_W-1:0] hi);
		drain();
		write_reg(CFG_SECTORS_PER_PAGE, spp_word);
		write_reg(CFG_RANGE_START, lo);
		write_reg(CFG_RANGE_END, hi);
		cfg_valid <= 1'b0;
		sb.settings++;
	endtask

	task automatic issue(input logic [SECTOR_W-1:0] lsa, input logic [REQ_W-1:0] n,
	                     input logic wr);
		cmd_t c;
		c.start_sector = lsa;
		c.request_sectors = n;
		c.is_write = wr;
		send_cmd(c);
		pause_sender(pick_gap());
	endtask

	task automatic random_phase(input logic [SECTOR_W-1:0] spp_word,
	                            input logic [SECTOR_W-1:0] lo, input logic [SECTOR_W-1:0] hi,
	                            input int unsigned count, input bit steady);
		apply_config(spp_word, lo, hi);
		repeat (count) begin
			send_cmd(random_cmd(64'(lo), 64'(hi)));
			if ($urandom_range(0, 19) == 0) begin
				drain();
			end else begin
				pause_sender(steady ? 0 : pick_gap());
			end
		end
	endtask

	initial begin
		logic [SECTOR_W-1:0] lo;
		sb = new;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SECTORS_PER_PAGE;
		cfg_data = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers still at their reset values.
		issue('0, '0, 1'b0);
		issue(SECTOR_MAX, '0, 1'b1);
		issue('0, 16'd1, 1'b0);
		issue(48'd3, 16'd256, 1'b1);
		issue('0, 16'd256, 1'b0);
		issue(SECTOR_MAX, 16'd5, 1'b1);
		issue(48'd5, 16'd257, 1'b0);
		issue(SECTOR_MAX, 16'hffff, 1'b1);
		issue(48'h5555_5555_5555, 16'd13, 1'b0);
		issue(48'hAAAA_AAAA_AAAA, 16'd19, 1'b1);

		// Largest page with a range start off the page grid, so masks spill.
		apply_config(48'd64, 48'd1000, 48'd1000000);
		issue(48'd1000, 16'd256, 1'b1);
		issue(48'd5, 16'd70, 1'b0);
		issue(48'd1000000, 16'd64, 1'b1);

		// A four-sector range: long requests wrap past the piece limit.
		apply_config(48'd8, 48'd100, 48'd103);
		issue(48'd100, 16'd256, 1'b0);
		issue(48'd103, 16'd3, 1'b1);
		issue('0, '0, 1'b1);

		// Empty and inverted ranges.
		apply_config(48'd8, 48'd500, 48'd500);
		issue(48'd500, 16'd4, 1'b1);
		issue(48'd500, '0, 1'b0);
		apply_config(48'd8, 48'd500, 48'd499);
		issue('0, 16'd10, 1'b0);

		// Page sizes just outside the legal span; the second word carries junk in
		// its upper bits and 65 in its low seven.
		apply_config(48'd7, '0, SECTOR_MAX);
		issue('0, 16'd8, 1'b1);
		apply_config(48'hFFFF_FFFF_FFC1, '0, SECTOR_MAX);
		issue('0, 16'd8, 1'b0);

		random_phase(48'd8, '0, SECTOR_MAX, 17, 1'b0);
		lo = SECTOR_W'({$urandom, $urandom});
		random_phase(48'd64, lo, range_top(64'(lo), 64'($urandom_range(1, 1 << 24))), 17, 1'b1);
		lo = SECTOR_W'({$urandom, $urandom});
		random_phase(SECTOR_W'($urandom_range(8, 64)), lo,
			range_top(64'(lo), 64'($urandom_range(1, 300))), 17, 1'b0);
		random_phase(SECTOR_W'($urandom_range(8, 64)), '0,
			SECTOR_W'({$urandom, $urandom}) | 48'd1, 17, 1'b0);
		lo = SECTOR_MAX - SECTOR_W'($urandom_range(1, 5000));
		random_phase(SECTOR_W'($urandom_range(8, 64)), lo, SECTOR_MAX, 17, 1'b0);
		lo = SECTOR_W'({$urandom, $urandom});
		random_phase(SECTOR_W'($urandom_range(8, 64)), lo,
			range_top(64'(lo), ({$urandom, $urandom} >> $urandom_range(0, 40)) + 64'd1),
			17, 1'b0);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.close_out();
		$display("Covered %0d requests (%0d empty, %0d expected error beats) and %0d result beats",
			sb.requests, sb.empty_requests, sb.rejects, sb.beats);
		$display("across %0d register settings, from a four-sector range to the full space.",
			sb.settings);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
